>>> hdl/isp_pkg.sv
// Shared types, codes and default sizes for the interpolating sample player.
`default_nettype none

package isp_pkg;

    // Default sizes handed to the top level parameters.
    localparam int MAX_FRAMES_DEF   = 65536;
    localparam int MAX_CHANNELS_DEF = 2;
    localparam int SAMPLE_BITS_DEF  = 16;

    // Fixed field widths.
    localparam int POS_W      = 32;
    localparam int RATE_W     = 24;
    localparam int RATIO_W    = 20;
    localparam int FCOUNT_W   = 17;
    localparam int CCOUNT_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int S_USER_W   = 3;
    localparam int M_USER_W   = 1;

    // Operation carried in the input beat.
    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_INTERP  = 2'd1,
        OP_RAW     = 2'd2,
        OP_ADVANCE = 2'd3
    } op_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PLAY_RATE      = 2'd0,
        CFG_RESAMPLE_RATIO = 2'd1,
        CFG_FRAME_COUNT    = 2'd2,
        CFG_CHANNEL_COUNT  = 2'd3
    } cfg_idx_t;

    // Configuration reset values.
    localparam logic [RATE_W-1:0]   PLAY_RATE_RST      = 24'd65536;
    localparam logic [RATIO_W-1:0]  RESAMPLE_RATIO_RST = 20'd65536;
    localparam logic [FCOUNT_W-1:0] FRAME_COUNT_RST    = 17'd65536;
    localparam logic [CCOUNT_W-1:0] CHANNEL_COUNT_RST  = 2'd1;

endpackage

`default_nettype wire

>>> hdl/isp_sample_ram.sv
// Sample memory with one write port and two registered read ports.
`default_nettype none

module isp_sample_ram #(
    parameter int DEPTH = 131072,
    parameter int AW    = 17,
    parameter int DW    = 16
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr_a,
    input  wire logic [AW-1:0] raddr_b,
    output logic      [DW-1:0] rdata_a,
    output logic      [DW-1:0] rdata_b
);

    logic [DW-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Two read ports; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

>>> hdl/interpolating_sample_player_core.sv
// Top level of the interpolating sample player: sequencer, arithmetic and output register.
`default_nettype none

// Each input beat loads a sample, reads a linearly interpolated or a raw sample, or
// advances the looping playhead, and yields exactly one output beat. The accepting edge
// starts the dual-port sample memory read. The multiply state registers the
// interpolation product and the playhead sum. The final state does the rounding and
// the loop wrap and writes the output register once that register is free. The step
// size is recomputed every cycle from the rate and ratio registers. A new beat can be
// accepted in the cycle after the output register is written, so the block takes a
// new item only once it is through with the last. While a stalled result occupies the
// output register, the next item waits in its last stage, and acceptance is delayed by
// the length of the stall. The output register lets a finished result wait while the
// next item is accepted and worked on. Configuration writes take effect at once and are
// expected only while no item is in flight. The sample memory has no reset; reading a
// location that was never loaded returns undefined data.
module interpolating_sample_player_core #(
    parameter int MAX_FRAMES   = isp_pkg::MAX_FRAMES_DEF,
    parameter int MAX_CHANNELS = isp_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_BITS  = isp_pkg::SAMPLE_BITS_DEF,
    localparam int IN_W  = ((isp_pkg::POS_W + SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((SAMPLE_BITS + isp_pkg::POS_W + 7) / 8) * 8
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Input stream.
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [IN_W-1:0]                  s_tdata,   // position, sample_in
    input  wire logic [isp_pkg::S_USER_W-1:0]     s_tuser,   // opcode, channel
    // Output stream.
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [OUT_W-1:0]                 m_tdata,   // sample_out, playhead
    output logic      [isp_pkg::M_USER_W-1:0]     m_tuser,   // in_range
    // Configuration write port.
    input  wire logic                             cfg_we,
    input  wire logic [isp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [isp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    import isp_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int DEPTH = MAX_FRAMES * MAX_CHANNELS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [20:0] MAXF_W   = 21'(MAX_FRAMES);
    localparam logic [3:0]  MAXC_W   = 4'(MAX_CHANNELS);
    localparam logic [AW-1:0] CH_BASE = AW'(MAX_FRAMES);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MUL  = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    // Input beat fields.
    logic [POS_W-1:0] in_position;
    logic [SB-1:0]    in_sample;
    op_t              in_op;
    logic             in_channel;
    assign in_position = s_tdata[POS_W-1:0];
    assign in_sample   = s_tdata[POS_W+SB-1:POS_W];
    assign in_op       = op_t'(s_tuser[1:0]);
    assign in_channel  = s_tuser[2];

    // Configuration registers.
    logic [RATE_W-1:0]   play_rate_reg;
    logic [RATIO_W-1:0]  resample_ratio_reg;
    logic [FCOUNT_W-1:0] frame_count_reg;
    logic [CCOUNT_W-1:0] channel_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            play_rate_reg      <= PLAY_RATE_RST;
            resample_ratio_reg <= RESAMPLE_RATIO_RST;
            frame_count_reg    <= FRAME_COUNT_RST;
            channel_count_reg  <= CHANNEL_COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_PLAY_RATE:      play_rate_reg      <= cfg_wdata[RATE_W-1:0];
                CFG_RESAMPLE_RATIO: resample_ratio_reg <= cfg_wdata[RATIO_W-1:0];
                CFG_FRAME_COUNT:    frame_count_reg    <= cfg_wdata[FCOUNT_W-1:0];
                CFG_CHANNEL_COUNT:  channel_count_reg  <= cfg_wdata[CCOUNT_W-1:0];
            endcase
        end
    end

    // Effective frame and channel counts, clamped to at least one and the memory size.
    logic [FCOUNT_W-1:0] frames_used;
    logic [3:0]          channels_used;
    always_comb
    begin
        if (frame_count_reg == '0)
            frames_used = FCOUNT_W'(1);
        else if ({4'b0, frame_count_reg} > MAXF_W)
            frames_used = MAXF_W[FCOUNT_W-1:0];
        else
            frames_used = frame_count_reg;

        if (channel_count_reg == '0)
            channels_used = 4'd1;
        else if ({2'b0, channel_count_reg} > MAXC_W)
            channels_used = MAXC_W;
        else
            channels_used = {2'b0, channel_count_reg};
    end

    // Step size: rate times ratio, floored to signed Q12.16, refreshed every cycle.
    logic signed [RATE_W-1:0]  rate_s;
    logic signed [RATIO_W:0]   ratio_s;
    logic signed [44:0]        step_prod;
    logic signed [27:0]        step_reg;
    assign rate_s    = play_rate_reg;
    assign ratio_s   = {1'b0, resample_ratio_reg};
    assign step_prod = rate_s * ratio_s;

    always_ff @(posedge clk)
    begin
        step_reg <= step_prod[43:16];
    end

    // Address generation and range check on the incoming beat.
    logic [15:0]   in_frame;
    logic [16:0]   in_up_raw;
    logic [16:0]   in_up;
    logic          in_hit;
    logic [AW-1:0] lo_addr;
    logic [AW-1:0] hi_addr;
    logic [AW-1:0] ch_base;
    assign in_frame  = in_position[31:16];
    assign in_up_raw = {1'b0, in_frame} + 17'd1;
    assign in_up     = (in_up_raw >= frames_used) ? 17'd0 : in_up_raw;
    assign in_hit    = ({3'b0, in_channel} < channels_used)
                       && ({1'b0, in_frame} < frames_used);
    assign ch_base   = in_channel ? CH_BASE : '0;
    assign lo_addr   = ch_base + AW'(in_frame);
    assign hi_addr   = ch_base + AW'(in_up);

    // Sequencer.
    state_t state_reg, state_next;
    logic   accept;
    logic   fin_go;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign fin_go   = (state_reg == ST_FIN) && (!m_tvalid || m_tready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_MUL;
            ST_MUL:  state_next = ST_FIN;
            ST_FIN:  if (fin_go) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Sample memory: in-range loads write at acceptance, reads fetch both neighbors.
    logic [SB-1:0] rd_lo;
    logic [SB-1:0] rd_hi;

    isp_sample_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (SB)
    ) u_ram (
        .clk     (clk),
        .we      (accept && (in_op == OP_LOAD) && in_hit),
        .waddr   (lo_addr),
        .wdata   (in_sample),
        .re      (accept),
        .raddr_a (lo_addr),
        .raddr_b (hi_addr),
        .rdata_a (rd_lo),
        .rdata_b (rd_hi)
    );

    // Item registers captured at acceptance.
    op_t         op_reg;
    logic        hit_reg;
    logic [15:0] frac_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= in_op;
            hit_reg  <= in_hit;
            frac_reg <= in_position[15:0];
        end
    end

    // Multiply stage: neighbor difference times fraction, and playhead plus step.
    logic [POS_W-1:0]   playhead_reg, playhead_next;
    logic signed [SB:0]    diff;
    logic signed [16:0]    frac_s;
    logic signed [SB+17:0] prod_next;
    logic signed [SB+17:0] prod_reg;
    logic signed [33:0]    psum_next;
    logic signed [33:0]    psum_reg;
    assign diff      = $signed({rd_hi[SB-1], rd_hi}) - $signed({rd_lo[SB-1], rd_lo});
    assign frac_s    = {1'b0, frac_reg};
    assign prod_next = diff * frac_s;
    assign psum_next = $signed({2'b00, playhead_reg}) + $signed({{6{step_reg[27]}}, step_reg});

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            prod_reg <= prod_next;
            psum_reg <= psum_next;
        end
    end

    // Final stage: rounding of the interpolation and one wrap of the playhead.
    logic signed [SB+17:0] interp_sum;
    logic signed [33:0]    loop_len;
    logic signed [33:0]    p_wrap;
    logic                  p_ok;
    logic [SB-1:0]         sample_next;
    logic                  flag_next;

    assign interp_sum = $signed({{2{rd_lo[SB-1]}}, rd_lo, 16'd0}) + prod_reg
                        + $signed((SB+18)'(32768));
    assign loop_len   = (frames_used > 17'd65536) ? 34'sh1_0000_0000
                                                  : $signed({1'b0, frames_used, 16'd0});

    always_comb
    begin
        if (psum_reg >= loop_len)
            p_wrap = psum_reg - loop_len;
        else if (psum_reg < 0)
            p_wrap = psum_reg + loop_len;
        else
            p_wrap = psum_reg;
        p_ok = !((p_wrap < 0) || (p_wrap >= loop_len));
    end

    always_comb
    begin
        sample_next   = '0;
        flag_next     = hit_reg;
        playhead_next = playhead_reg;
        unique case (op_reg)
            OP_LOAD:    sample_next = '0;
            OP_INTERP:  if (hit_reg) sample_next = interp_sum[SB+15:16];
            OP_RAW:     if (hit_reg) sample_next = rd_lo;
            OP_ADVANCE:
            begin
                flag_next     = p_ok;
                playhead_next = p_ok ? p_wrap[31:0] : '0;
            end
        endcase
    end

    // Control state and output register.
    logic             m_valid_reg;
    logic [SB-1:0]    out_sample_reg;
    logic [POS_W-1:0] out_playhead_reg;
    logic             out_flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            playhead_reg <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fin_go)
            begin
                playhead_reg <= playhead_next;
                m_valid_reg  <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_go)
        begin
            out_sample_reg   <= sample_next;
            out_playhead_reg <= playhead_next;
            out_flag_reg     <= flag_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'({out_playhead_reg, out_sample_reg});
    assign m_tuser  = out_flag_reg;

endmodule

`default_nettype wire

>>> hdl/isp_checker.sv
// Port-level checker for the interpolating sample player, bound to the top level.
`default_nettype none

module isp_checker #(
    parameter int SAMPLE_BITS  = isp_pkg::SAMPLE_BITS_DEF,
    localparam int OUT_W = ((SAMPLE_BITS + isp_pkg::POS_W + 7) / 8) * 8
) (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [OUT_W-1:0]               m_tdata,
    input wire logic [isp_pkg::M_USER_W-1:0]   m_tuser
);

    logic in_beat;
    assign in_beat = s_tvalid && s_tready;

    // A stalled result beat holds its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output beat changed while stalled");

    // Only one item is in work at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !s_tready)
        else $error("input accepted while an item was in work");

    // Every accepted item has a result waiting once it has passed the multiply and final states.
    a_result_due: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |-> ##3 m_tvalid)
        else $error("result missing three cycles after acceptance");

    // A result only appears from an empty output as the product of an accepted item.
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(in_beat, 3))
        else $error("result appeared without an accepted item");

    // An out-of-range or clamped result carries a zero sample.
    a_zero_sample: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[SAMPLE_BITS-1:0] == '0)
        else $error("nonzero sample on an out-of-range result");

endmodule

bind interpolating_sample_player_core isp_checker #(
    .SAMPLE_BITS  (SAMPLE_BITS)
) u_isp_checker (.*);

`default_nettype wire
